FILE: src/hrba_pkg.sv
// ----------------------------------------------------------------------------
// hrba_pkg
// Shared types, widths and constants for the heart rate beat averager.
// ----------------------------------------------------------------------------
package hrba_pkg;

    // Field widths
    localparam int IR_W   = 18;
    localparam int TIME_W = 32;
    localparam int BPM_W  = 16;
    localparam int AVG_W  = 8;
    localparam int RATE_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_FINGER_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_FLOOR       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_CEILING     = 2'd2;

    localparam logic [IR_W-1:0]   FINGER_THRESHOLD_RST = 18'd50000;
    localparam logic [RATE_W-1:0] RATE_FLOOR_RST       = 8'd20;
    localparam logic [RATE_W-1:0] RATE_CEILING_RST     = 8'd255;

    // Milliseconds per minute, the fixed dividend of the rate divide
    localparam logic [BPM_W-1:0] MS_PER_MINUTE = 16'd60000;

    // Rate history ring
    localparam int RING_DEPTH = 4;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int SUM_W      = RATE_W + CNT_W;

    // Shared restoring divider: 16-bit dividend, 31-bit divisor
    localparam int DIV_N_W   = BPM_W;
    localparam int DIV_D_W   = TIME_W - 1;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } hrba_div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_N_W-1:0] quotient;
        logic [DIV_D_W-1:0] remainder;
    } hrba_div_rsp_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE_DIV,
        S_SCAN,
        S_AVG_DIV,
        S_FINISH
    } hrba_state_t;

endpackage

FILE: src/hrba_if.sv
// ----------------------------------------------------------------------------
// hrba_if
// Valid/ready channels for sample requests and result requests.
// ----------------------------------------------------------------------------
interface hrba_sample_if import hrba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IR_W-1:0]   ir_level;
    logic              beat_seen;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, output ir_level, output beat_seen, output time_ms,
                    input ready);
    modport sink   (input valid, input ir_level, input beat_seen, input time_ms,
                    output ready);
endinterface

interface hrba_result_if import hrba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [BPM_W-1:0] instant_bpm;
    logic [AVG_W-1:0] average_bpm;
    logic             rate_accepted;
    logic             finger_present;

    modport source (output valid, output instant_bpm, output average_bpm,
                    output rate_accepted, output finger_present, input ready);
    modport sink   (input valid, input instant_bpm, input average_bpm,
                    input rate_accepted, input finger_present, output ready);
endinterface

FILE: src/heart_rate_beat_averager.sv
// ----------------------------------------------------------------------------
// heart_rate_beat_averager
// Beat interval to bpm, range check, ring of recent rates and their mean.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  sample    in   valid/ready   ir_level[17:0], beat_seen, time_ms[31:0]
//  result    out  valid/ready   instant_bpm[15:0], average_bpm[7:0],
//                               rate_accepted, finger_present
//  cfg       in   cfg_wr_en     cfg_index[1:0], cfg_wr_data[17:0]
//
//  An accepted beat runs the rate divide, a scan of the ring and, if the
//  ring holds a nonzero rate, the mean divide, all on the 16-step shared
//  divider; a rejected beat skips the scan and the mean, and other samples
//  go straight to the result. A new sample waits until the result is loaded.
//  Reset clears ring, pointer, beat time, rate and average; sets cfg defaults.
//  One result register: the next sample is taken while a result waits, and
//  the sequencer holds before loading a new result until the old one leaves.
// ----------------------------------------------------------------------------
module heart_rate_beat_averager import hrba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    hrba_sample_if.sink           sample,
    hrba_result_if.source         result
);

    hrba_state_t state_reg, state_next;

    // Configuration
    logic [IR_W-1:0]   thresh_reg;
    logic [RATE_W-1:0] floor_reg;
    logic [RATE_W-1:0] ceil_reg;

    // History state
    logic [RATE_W-1:0] ring_reg [RING_DEPTH];
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [TIME_W-1:0] last_beat_reg, last_beat_next;
    logic [BPM_W-1:0]  rate_reg, rate_next;
    logic [AVG_W-1:0]  avg_reg, avg_next;

    // Per-sample working registers
    logic [IR_W-1:0]  ir_reg, ir_next;
    logic             acc_reg, acc_next;
    logic [PTR_W-1:0] idx_reg, idx_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Result register
    logic             out_valid_reg, out_valid_next;
    logic [BPM_W-1:0] out_bpm_reg;
    logic [AVG_W-1:0] out_avg_reg;
    logic             out_acc_reg;
    logic             out_present_reg;

    hrba_div_req_t div_req;
    hrba_div_rsp_t div_rsp;

    logic              accept;
    logic [TIME_W-1:0] delta;
    logic              delta_ok;
    logic              range_ok;
    logic              ring_wr;
    logic              present;
    logic              scan_last;
    logic              out_load;
    logic [RATE_W-1:0] ring_rd;

    hrba_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Decode helpers
    assign accept    = sample.valid && sample.ready;
    assign delta     = sample.time_ms - last_beat_reg;
    assign delta_ok  = sample.beat_seen && (delta != '0) && !delta[TIME_W-1];
    assign ring_rd   = ring_reg[idx_reg];
    assign scan_last = (idx_reg == PTR_W'(RING_DEPTH - 1));
    assign present   = (ir_reg >= thresh_reg);

    // Exact range test from quotient and remainder:
    //   60000 > floor*d  <=>  floor < q, or floor == q with nonzero remainder
    //   60000 < ceil*d   <=>  ceil > q
    always_comb
    begin
        range_ok = ((BPM_W'(floor_reg) < div_rsp.quotient) ||
                    ((BPM_W'(floor_reg) == div_rsp.quotient) &&
                     (div_rsp.remainder != '0))) &&
                   (BPM_W'(ceil_reg) > div_rsp.quotient);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = delta_ok ? S_RATE_DIV : S_FINISH;
            end
            S_RATE_DIV:
            begin
                if (div_rsp.done)
                    state_next = range_ok ? S_SCAN : S_FINISH;
            end
            S_SCAN:
            begin
                if (scan_last)
                    state_next = (cnt_next != '0) ? S_AVG_DIV : S_FINISH;
            end
            S_AVG_DIV:
            begin
                if (div_rsp.done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        sample.ready     = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = MS_PER_MINUTE;
        div_req.divisor  = delta[DIV_D_W-1:0];
        ring_wr          = 1'b0;
        out_load         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                sample.ready  = 1'b1;
                div_req.start = sample.valid && delta_ok;
            end
            S_RATE_DIV:
                ring_wr = div_rsp.done && range_ok;
            S_SCAN:
            begin
                div_req.start    = scan_last && (cnt_next != '0);
                div_req.dividend = DIV_N_W'(sum_next);
                div_req.divisor  = DIV_D_W'(cnt_next);
            end
            S_FINISH:
                out_load = !out_valid_reg || result.ready;
            default:
            begin
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        ptr_next       = ptr_reg;
        last_beat_next = last_beat_reg;
        rate_next      = rate_reg;
        avg_next       = avg_reg;
        ir_next        = ir_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ir_next  = sample.ir_level;
                    acc_next = 1'b0;
                    if (sample.beat_seen)
                        last_beat_next = sample.time_ms;
                end
            end
            S_RATE_DIV:
            begin
                if (div_rsp.done)
                begin
                    rate_next = div_rsp.quotient;
                    if (range_ok)
                    begin
                        acc_next = 1'b1;
                        ptr_next = (ptr_reg == PTR_W'(RING_DEPTH - 1)) ?
                                   '0 : ptr_reg + 1'b1;
                        idx_next = '0;
                        sum_next = '0;
                        cnt_next = '0;
                    end
                end
            end
            S_SCAN:
            begin
                // Accumulate nonzero entries, one per cycle
                if (ring_rd != '0)
                begin
                    sum_next = sum_reg + SUM_W'(ring_rd);
                    cnt_next = cnt_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            S_AVG_DIV:
            begin
                if (div_rsp.done)
                    avg_next = div_rsp.quotient[AVG_W-1:0];
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (!present)
                    begin
                        ptr_next  = '0;
                        rate_next = '0;
                        avg_next  = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer and history state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            last_beat_reg <= '0;
            rate_reg      <= '0;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            last_beat_reg <= last_beat_next;
            rate_reg      <= rate_next;
            avg_reg       <= avg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Rate ring: written at the pointer, cleared when no finger
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
                ring_reg[i] <= '0;
        end
        else if (out_load && !present)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
                ring_reg[i] <= '0;
        end
        else if (ring_wr)
        begin
            ring_reg[ptr_reg] <= div_rsp.quotient[RATE_W-1:0];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= FINGER_THRESHOLD_RST;
            floor_reg  <= RATE_FLOOR_RST;
            ceil_reg   <= RATE_CEILING_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FINGER_THRESHOLD: thresh_reg <= cfg_wr_data[IR_W-1:0];
                REG_RATE_FLOOR:       floor_reg  <= cfg_wr_data[RATE_W-1:0];
                REG_RATE_CEILING:     ceil_reg   <= cfg_wr_data[RATE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        ir_reg  <= ir_next;
        acc_reg <= acc_next;
        idx_reg <= idx_next;
        sum_reg <= sum_next;
        cnt_reg <= cnt_next;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_bpm_reg     <= rate_next;
            out_avg_reg     <= avg_next;
            out_acc_reg     <= acc_reg;
            out_present_reg <= present;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.instant_bpm    = out_bpm_reg;
    assign result.average_bpm    = out_avg_reg;
    assign result.rate_accepted  = out_acc_reg;
    assign result.finger_present = out_present_reg;

`ifndef SYNTHESIS
    // No finger means the history was cleared in this result
    a_clear_on_absent: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.finger_present |->
            result.instant_bpm == '0 && result.average_bpm == '0)
        else $error("result without finger carries nonzero rate or average");

    // Samples are only taken while the divider is free
    a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready |-> !div_rsp.busy)
        else $error("sample taken while divider busy");

    // A divider completion is only seen while waiting for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_RATE_DIV || state_reg == S_AVG_DIV))
        else $error("divider finished outside a wait state");

    // An accepted rate stays under the ceiling
    a_accept_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.rate_accepted && result.finger_present |->
            result.instant_bpm < BPM_W'(ceil_reg))
        else $error("accepted rate at or above ceiling");
`endif

endmodule

FILE: src/hrba_div.sv
// ----------------------------------------------------------------------------
// hrba_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hrba_div import hrba_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  hrba_div_req_t req,
    output hrba_div_rsp_t rsp
);

    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIV_D_W:0] trial;
    logic [DIV_D_W:0] diff;
    logic             ge;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_N_W-1]};
        ge    = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = DIV_CNT_W'(DIV_N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_N_W-2:0], ge};
            rem_next = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: verif/tb_heart_rate_beat_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heart_rate_beat_averager
// Self-checking bench: sends IR samples with beat flags and timestamps,
// predicts rate, ring average, accept and finger flags per sample, and checks
// every result in order under random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_heart_rate_beat_averager import hrba_pkg::*; ();

    localparam int                CLK_HALF       = 5;
    localparam int                QUIET_LIMIT    = 2000;
    localparam int                SETTLE_CYCLES  = 60;
    localparam logic [IR_W-1:0]   IR_MAX         = '1;
    localparam logic [TIME_W-1:0] MINUTE_MS      = 32'd60000;

    typedef struct packed {
        logic [BPM_W-1:0] instant_bpm;
        logic [AVG_W-1:0] average_bpm;
        logic             rate_accepted;
        logic             finger_present;
    } bpm_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  rx_ready = 1'b0;

    hrba_sample_if sample_ch ();
    hrba_result_if result_ch ();

    assign result_ch.ready = rx_ready;

    heart_rate_beat_averager DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .sample      (sample_ch),
        .result      (result_ch)
    );

    always #CLK_HALF clk = ~clk;

    // Predictor state: register copies and rate history
    logic [IR_W-1:0]   thr_cfg;
    logic [RATE_W-1:0] floor_cfg;
    logic [RATE_W-1:0] ceil_cfg;
    logic [RATE_W-1:0] hist_rates [RING_DEPTH];
    logic [PTR_W-1:0]  hist_ptr;
    logic [TIME_W-1:0] last_beat_ms;
    logic [BPM_W-1:0]  rate_now;
    logic [AVG_W-1:0]  avg_now;

    bpm_result_t       pending_bpm [$];
    int                error_count = 0;
    bit                tx_gap_en = 1'b1;
    bit                rx_stall_en = 1'b1;
    int                rx_stall = 0;
    logic [TIME_W-1:0] gen_time;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void clear_rate_history();
        for (int k = 0; k < RING_DEPTH; k++)
            hist_rates[k] = '0;
        hist_ptr = '0;
        rate_now = '0;
        avg_now  = '0;
    endfunction

    // Advance the history by one sample and return the result it produces
    function automatic bpm_result_t predict_bpm(input logic [IR_W-1:0]   ir,
                                                input logic              beat,
                                                input logic [TIME_W-1:0] stamp);
        bpm_result_t       res;
        logic [TIME_W-1:0] interval;
        logic [47:0]       low_bound;
        logic [47:0]       high_bound;
        int unsigned       sum;
        int unsigned       filled;
        res = '0;
        if (beat) begin
            interval     = stamp - last_beat_ms;
            last_beat_ms = stamp;
            // zero or backwards interval leaves rate and ring alone
            if (interval != '0 && !interval[TIME_W-1]) begin
                rate_now   = BPM_W'(MINUTE_MS / interval);
                low_bound  = 48'(floor_cfg) * 48'(interval);
                high_bound = 48'(ceil_cfg) * 48'(interval);
                // exact range test on the real quotient
                if (48'(MINUTE_MS) > low_bound && 48'(MINUTE_MS) < high_bound) begin
                    hist_rates[hist_ptr] = rate_now[RATE_W-1:0];
                    hist_ptr = (hist_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : hist_ptr + 1'b1;
                    sum    = 0;
                    filled = 0;
                    for (int k = 0; k < RING_DEPTH; k++) begin
                        if (hist_rates[k] != '0) begin
                            sum    += 32'(hist_rates[k]);
                            filled++;
                        end
                    end
                    // all-empty ring keeps the old average
                    if (filled != 0)
                        avg_now = AVG_W'(sum / filled);
                    res.rate_accepted = 1'b1;
                end
            end
        end
        res.finger_present = (ir >= thr_cfg);
        if (!res.finger_present)
            clear_rate_history();
        res.instant_bpm = rate_now;
        res.average_bpm = avg_now;
        return res;
    endfunction

    // Send one sample request and queue its expected result on acceptance
    task automatic send_sample(input logic [IR_W-1:0]   ir,
                               input logic              beat,
                               input logic [TIME_W-1:0] stamp);
        int gap;
        gap = tx_gap_en ? pick_gap() : 0;
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.ir_level  <= ir;
        sample_ch.beat_seen <= beat;
        sample_ch.time_ms   <= stamp;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        pending_bpm.push_back(predict_bpm(ir, beat, stamp));
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_for_results();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_bpm.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FINGER_THRESHOLD: thr_cfg   = data[IR_W-1:0];
            REG_RATE_FLOOR:       floor_cfg = data[RATE_W-1:0];
            REG_RATE_CEILING:     ceil_cfg  = data[RATE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_registers(input logic [IR_W-1:0]   thr,
                                 input logic [RATE_W-1:0] lo,
                                 input logic [RATE_W-1:0] hi);
        write_reg(REG_FINGER_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_RATE_FLOOR, CFG_DATA_W'(lo));
        write_reg(REG_RATE_CEILING, CFG_DATA_W'(hi));
    endtask

    // Field extremes and interval corner cases at reset register values
    task automatic test_directed_edges();
        send_sample('0, 1'b0, '0);
        send_sample(IR_MAX, 1'b0, 32'hFFFF_FFFF);
        send_sample(18'd49999, 1'b0, '0);
        send_sample(18'd50000, 1'b1, 32'd1000);     // first beat, 60 bpm
        send_sample(18'd50000, 1'b1, 32'd1000);     // zero interval
        send_sample(18'd60000, 1'b1, 32'd500);      // timestamp went backwards
        send_sample(18'd60000, 1'b1, 32'd501);      // 60000 bpm, above ceiling
        send_sample(18'd60000, 1'b1, 32'd3428);     // 20.5 bpm passes, stored as 20
        send_sample(18'd60000, 1'b1, 32'd6428);     // exactly 20, rejected
        send_sample(18'd60000, 1'b1, 32'd6664);     // 254.2 accepted
        send_sample(18'd60000, 1'b1, 32'd6899);     // 255.3 rejected
        send_sample(18'd60000, 1'b1, 32'd7399);
        send_sample(18'd60000, 1'b1, 32'd8399);     // ring wraps
        send_sample(18'd1000, 1'b1, 32'd9149);      // accepted, then cleared
        send_sample(IR_MAX, 1'b1, 32'hFFFF_FFF0);
        send_sample(IR_MAX, 1'b1, 32'h0000_0010);   // wrapping interval
        send_sample(IR_MAX, 1'b1, 32'h8000_000F);   // largest positive interval
        send_sample(IR_MAX, 1'b1, 32'h0000_0010);
        send_sample(IR_MAX, 1'b1, 32'h8000_0010);   // interval of 2^31, negative
        send_sample(IR_MAX, 1'b1, 32'h8000_0369);
        send_sample(18'd70000, 1'b0, 32'h8000_0400);
    endtask

    // Registers at their extremes: zero rates, empty ring, narrow windows
    task automatic test_register_extremes();
        logic [TIME_W-1:0] t;
        t = 32'h8000_0400;
        set_registers('0, 8'd20, 8'd255);
        t += 1000;
        send_sample('0, 1'b1, t);
        set_registers('0, 8'd0, 8'd255);
        // zero rates fill the ring; the average holds its last value
        repeat (RING_DEPTH + 1) begin
            t += 70000;
            send_sample('0, 1'b1, t);
        end
        set_registers('0, 8'd0, 8'd1);
        t += 60001;
        send_sample(18'd5, 1'b1, t);
        t += 60000;
        send_sample(18'd5, 1'b1, t);
        set_registers(IR_MAX, 8'd255, 8'd255);
        t += 300;
        send_sample(IR_MAX - 18'd1, 1'b1, t);
        t += 300;
        send_sample(IR_MAX, 1'b1, t);
        t += 236;
        send_sample(IR_MAX, 1'b1, t);
        set_registers(IR_MAX, 8'd254, 8'd255);
        t += 236;
        send_sample(IR_MAX, 1'b1, t);
        t += 235;
        send_sample(IR_MAX, 1'b1, t);
        gen_time = t;
    endtask

    // Mostly plausible heartbeats with a finger present, plus noise
    task automatic test_random_traffic(input int                count,
                                       input logic [IR_W-1:0]   thr,
                                       input logic [RATE_W-1:0] lo,
                                       input logic [RATE_W-1:0] hi,
                                       input bit                gaps);
        int              kind;
        logic [IR_W-1:0] ir;
        logic            beat;
        set_registers(thr, lo, hi);
        tx_gap_en   = gaps;
        rx_stall_en = gaps;
        repeat (count) begin
            kind = $urandom_range(0, 99);
            ir   = IR_W'($urandom_range(IR_MAX, thr));
            beat = 1'b1;
            if (kind < 70) begin
                gen_time += $urandom_range(220, 3100);
            end else if (kind < 82) begin
                gen_time += $urandom_range(1, 40);
                beat = 1'b0;
            end else if (kind < 90) begin
                gen_time += $urandom_range(1, 40);
                beat = 1'($urandom_range(0, 1));
                ir   = (thr == '0) ? '0 : IR_W'($urandom_range(thr - 1, 0));
            end else if (kind < 95) begin
                gen_time = $urandom();
                beat = 1'($urandom_range(0, 1));
                ir   = IR_W'($urandom_range(IR_MAX, 0));
            end else begin
                gen_time += $urandom_range(0, 70000);
                ir   = IR_W'($urandom_range(IR_MAX, 0));
            end
            send_sample(ir, beat, gen_time);
            if ($urandom_range(0, 49) == 0)
                wait_for_results();
        end
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // Result checking and receiver stalls
    always @(posedge clk) begin : result_checker
        bpm_result_t want;
        if (rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                if (pending_bpm.size() == 0) begin
                    $error("unexpected result request: instant_bpm %0d",
                           result_ch.instant_bpm);
                    error_count++;
                end else begin
                    want = pending_bpm.pop_front();
                    if (result_ch.instant_bpm !== want.instant_bpm) begin
                        $error("instant_bpm: expected %0d, got %0d",
                               want.instant_bpm, result_ch.instant_bpm);
                        error_count++;
                    end
                    if (result_ch.average_bpm !== want.average_bpm) begin
                        $error("average_bpm: expected %0d, got %0d",
                               want.average_bpm, result_ch.average_bpm);
                        error_count++;
                    end
                    if (result_ch.rate_accepted !== want.rate_accepted) begin
                        $error("rate_accepted: expected %0d, got %0d",
                               want.rate_accepted, result_ch.rate_accepted);
                        error_count++;
                    end
                    if (result_ch.finger_present !== want.finger_present) begin
                        $error("finger_present: expected %0d, got %0d",
                               want.finger_present, result_ch.finger_present);
                        error_count++;
                    end
                end
                if (rx_stall_en)
                    rx_stall = pick_gap();
            end else if (rx_stall_en && rx_stall == 0 && $urandom_range(0, 19) == 0) begin
                rx_stall = pick_gap();
            end
            if (rx_stall > 0) begin
                rx_ready <= 1'b0;
                rx_stall--;
            end else begin
                rx_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long with no request moving on either channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) ||
                (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("timeout: no request accepted for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Main sequence
    initial begin
        sample_ch.valid     <= 1'b0;
        sample_ch.ir_level  <= '0;
        sample_ch.beat_seen <= 1'b0;
        sample_ch.time_ms   <= '0;
        cfg_wr_en           <= 1'b0;
        cfg_index           <= REG_FINGER_THRESHOLD;
        cfg_wr_data         <= '0;
        thr_cfg      = FINGER_THRESHOLD_RST;
        floor_cfg    = RATE_FLOOR_RST;
        ceil_cfg     = RATE_CEILING_RST;
        last_beat_ms = '0;
        gen_time     = '0;
        clear_rate_history();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_register_extremes();
        test_random_traffic(110, 18'd50000, 8'd20, 8'd255, 1'b1);
        test_random_traffic(100, '0, 8'd0, 8'd255, 1'b0);
        test_random_traffic(90, IR_MAX, 8'd254, 8'd255, 1'b1);
        test_random_traffic(110, IR_W'($urandom_range(IR_MAX, 0)),
                            RATE_W'($urandom_range(100, 0)),
                            RATE_W'($urandom_range(255, 150)), 1'b1);
        test_random_traffic(100, 18'd1000, 8'd40, 8'd200, 1'b1);
        test_random_traffic(80, IR_MAX - 18'd1, 8'd0, 8'd1, 1'b1);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_bpm.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
